>>> rtl/core/rwoc_pkg.sv
`timescale 1ns / 1ps

package rwoc_pkg;

    // field widths fixed by the pixel and register formats
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 24;
    localparam int COORD_W  = 12;
    localparam int CFG_W    = 13;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam int MAX_DIMENSION_DEF = 4096;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_OFFSET_X      = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd1;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd4;
    localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] source_red;
        logic [CHAN_W-1:0] source_green;
        logic [CHAN_W-1:0] source_blue;
        logic [CHAN_W-1:0] source_alpha;
        logic [PIX_W-1:0]  existing_pixel;
    } t_in_item;

    typedef struct packed {
        logic               write_enable;
        logic [COORD_W-1:0] canvas_x;
        logic [COORD_W-1:0] canvas_y;
        logic [PIX_W-1:0]   blended_pixel;
        logic               last;
    } t_out_item;

    // offsets are two's complement, dimensions unsigned
    typedef struct packed {
        logic [CFG_W-1:0] offset_x;
        logic [CFG_W-1:0] offset_y;
        logic [CFG_W-1:0] window_width;
        logic [CFG_W-1:0] window_height;
        logic [CFG_W-1:0] canvas_width;
        logic [CFG_W-1:0] canvas_height;
    } t_cfg;

    // geometry of one item, worked out at the input side
    typedef struct packed {
        logic               on_canvas;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_pos_info;

endpackage

>>> rtl/core/rgba_window_over_compositor.sv
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_ready       i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready     o_out_item (t_out_item)
// config    input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one item per cycle sustained while i_out_ready is held high; an accepted item passes
// the input register, then the result register, with the blend multipliers and
// divide-by-255 between them, before o_out_valid rises
// the window counters advance when an item is accepted and are cleared by reset
// reset (i_rst_n low, synchronous) empties both stages and loads register defaults
// each stage holds its item while the one after it is stalled

module rgba_window_over_compositor #(
    parameter int MAX_DIMENSION = rwoc_pkg::MAX_DIMENSION_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rwoc_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rwoc_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rwoc_pkg::APB_AW-1:0] paddr,
    input  logic [rwoc_pkg::APB_DW-1:0] pwdata,
    output logic [rwoc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import rwoc_pkg::*;

    t_cfg      w_cfg;
    t_pos_info w_pos;
    t_out_item w_blend;
    logic      w_out_free;
    logic      w_s1_free;
    logic      w_in_accept;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    t_pos_info r_s1_pos;
    logic      r_out_valid;
    t_out_item r_out_item;

    // configuration registers
    rwoc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // window counters and clipping
    rwoc_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_in_accept),
        .i_cfg     (w_cfg),
        .o_pos     (w_pos)
    );

    // color mix on the registered item
    rwoc_blend u_blend (
        .i_item (r_s1_item),
        .i_pos  (r_s1_pos),
        .o_item (w_blend)
    );

    // stage flow control
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_free   = !r_s1_valid || w_out_free;
    assign w_in_accept = i_in_valid && w_s1_free;
    assign o_in_ready  = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_item <= i_in_item;
            r_s1_pos  <= w_pos;
        end
        if (r_s1_valid && w_out_free) begin
            r_out_item <= w_blend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // input stage only refuses an item when it is occupied
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid)
        else $error("input refused while input stage empty");

    // a blocked input stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_out_free |=> r_s1_valid && $stable(r_s1_item))
        else $error("input stage item lost under stall");

    // no write means zero address and color
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.write_enable |->
            o_out_item.canvas_x == '0 && o_out_item.canvas_y == '0 &&
            o_out_item.blended_pixel == '0)
        else $error("nonzero fields on a result without write");
`endif

endmodule

>>> rtl/core/rwoc_cfg.sv
`timescale 1ns / 1ps

module rwoc_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rwoc_pkg::APB_AW-1:0] paddr,
    input  logic [rwoc_pkg::APB_DW-1:0] pwdata,
    output logic [rwoc_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rwoc_pkg::t_cfg             o_cfg
);
    import rwoc_pkg::*;

    t_cfg             r_cfg;
    logic [2:0]       w_index;
    logic [CFG_W-1:0] w_wdata;
    logic [CFG_W-1:0] w_rdata;

    assign pready  = 1'b1;
    assign w_index = paddr[APB_AW-1:2];
    assign w_wdata = pwdata[CFG_W-1:0];
    assign o_cfg   = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x      <= '0;
            r_cfg.offset_y      <= '0;
            r_cfg.window_width  <= CFG_W'(1);
            r_cfg.window_height <= CFG_W'(1);
            r_cfg.canvas_width  <= CFG_W'(1);
            r_cfg.canvas_height <= CFG_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (w_index)
                REG_OFFSET_X:      r_cfg.offset_x      <= w_wdata;
                REG_OFFSET_Y:      r_cfg.offset_y      <= w_wdata;
                REG_WINDOW_WIDTH:  r_cfg.window_width  <= w_wdata;
                REG_WINDOW_HEIGHT: r_cfg.window_height <= w_wdata;
                REG_CANVAS_WIDTH:  r_cfg.canvas_width  <= w_wdata;
                REG_CANVAS_HEIGHT: r_cfg.canvas_height <= w_wdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_index)
            REG_OFFSET_X:      w_rdata = r_cfg.offset_x;
            REG_OFFSET_Y:      w_rdata = r_cfg.offset_y;
            REG_WINDOW_WIDTH:  w_rdata = r_cfg.window_width;
            REG_WINDOW_HEIGHT: w_rdata = r_cfg.window_height;
            REG_CANVAS_WIDTH:  w_rdata = r_cfg.canvas_width;
            REG_CANVAS_HEIGHT: w_rdata = r_cfg.canvas_height;
            default:           w_rdata = '0;
        endcase
    end

    assign prdata = {{(APB_DW-CFG_W){1'b0}}, w_rdata};

endmodule

>>> rtl/core/rwoc_position.sv
`timescale 1ns / 1ps

module rwoc_position #(
    parameter int MAX_DIMENSION = rwoc_pkg::MAX_DIMENSION_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  rwoc_pkg::t_cfg        i_cfg,
    output rwoc_pkg::t_pos_info   o_pos
);
    import rwoc_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
    localparam int SUM_W = DIM_W + 1;

    logic [CNT_W-1:0]        r_col;
    logic [CNT_W-1:0]        r_row;
    logic [CNT_W-1:0]        w_ww_m1;
    logic [CNT_W-1:0]        w_wh_m1;
    logic [CNT_W-1:0]        w_cw_m1;
    logic [CNT_W-1:0]        w_ch_m1;
    logic signed [SUM_W-1:0] w_dx;
    logic signed [SUM_W-1:0] w_dy;
    logic                    w_in_x;
    logic                    w_in_y;

    // dimension saturated to 1..MAX_DIMENSION, minus one
    function automatic logic [CNT_W-1:0] dim_m1(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] vw;
        vw = DIM_W'(v);
        if (v == '0) begin
            return '0;
        end else if (vw > DIM_W'(MAX_DIMENSION)) begin
            return CNT_W'(MAX_DIMENSION - 1);
        end else begin
            return CNT_W'(v - 1'b1);
        end
    endfunction

    assign w_ww_m1 = dim_m1(i_cfg.window_width);
    assign w_wh_m1 = dim_m1(i_cfg.window_height);
    assign w_cw_m1 = dim_m1(i_cfg.canvas_width);
    assign w_ch_m1 = dim_m1(i_cfg.canvas_height);

    // canvas position = signed offset + window counter
    assign w_dx = $signed({{(SUM_W-CFG_W){i_cfg.offset_x[CFG_W-1]}}, i_cfg.offset_x})
                + $signed({{(SUM_W-CNT_W){1'b0}}, r_col});
    assign w_dy = $signed({{(SUM_W-CFG_W){i_cfg.offset_y[CFG_W-1]}}, i_cfg.offset_y})
                + $signed({{(SUM_W-CNT_W){1'b0}}, r_row});

    // clip against the canvas
    assign w_in_x = !w_dx[SUM_W-1] &&
                    (w_dx[SUM_W-2:0] <= {{(SUM_W-1-CNT_W){1'b0}}, w_cw_m1});
    assign w_in_y = !w_dy[SUM_W-1] &&
                    (w_dy[SUM_W-2:0] <= {{(SUM_W-1-CNT_W){1'b0}}, w_ch_m1});

    assign o_pos.on_canvas = w_in_x && w_in_y;
    assign o_pos.x         = w_dx[COORD_W-1:0];
    assign o_pos.y         = w_dy[COORD_W-1:0];
    assign o_pos.last      = (r_col == w_ww_m1) && (r_row == w_wh_m1);

    // raster counters, wrap at or beyond the last column or row of the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            if (r_col >= w_ww_m1) begin
                r_col <= '0;
                if (r_row >= w_wh_m1) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/rwoc_blend.sv
`timescale 1ns / 1ps

module rwoc_blend (
    input  rwoc_pkg::t_in_item    i_item,
    input  rwoc_pkg::t_pos_info   i_pos,
    output rwoc_pkg::t_out_item   o_item
);
    import rwoc_pkg::*;

    logic              w_we;
    logic              w_opaque;
    logic [CHAN_W-1:0] w_r;
    logic [CHAN_W-1:0] w_g;
    logic [CHAN_W-1:0] w_b;

    // (s*a + d*(255-a) + 127) / 255, divide by 255 done as add and shift
    function automatic logic [CHAN_W-1:0] mix_channel(
        input logic [CHAN_W-1:0] s,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] a
    );
        logic [CHAN_W-1:0] na;
        logic [15:0]       ps;
        logic [15:0]       pd;
        logic [16:0]       acc;
        logic [16:0]       q;
        na  = 8'hFF - a;
        ps  = {8'd0, s} * {8'd0, a};
        pd  = {8'd0, d} * {8'd0, na};
        acc = {1'b0, ps} + {1'b0, pd} + 17'd127;
        q   = (acc + 17'd1 + {8'd0, acc[16:8]}) >> 8;
        return q[CHAN_W-1:0];
    endfunction

    assign w_we     = i_pos.on_canvas && (i_item.source_alpha != '0);
    assign w_opaque = &i_item.source_alpha;

    // per-channel mix, source passes through when opaque
    always_comb begin
        if (w_opaque) begin
            w_r = i_item.source_red;
            w_g = i_item.source_green;
            w_b = i_item.source_blue;
        end else begin
            w_r = mix_channel(i_item.source_red,   i_item.existing_pixel[23:16],
                              i_item.source_alpha);
            w_g = mix_channel(i_item.source_green, i_item.existing_pixel[15:8],
                              i_item.source_alpha);
            w_b = mix_channel(i_item.source_blue,  i_item.existing_pixel[7:0],
                              i_item.source_alpha);
        end
    end

    // fields other than last read zero when nothing is written
    assign o_item.write_enable  = w_we;
    assign o_item.canvas_x      = w_we ? i_pos.x : '0;
    assign o_item.canvas_y      = w_we ? i_pos.y : '0;
    assign o_item.blended_pixel = w_we ? {w_r, w_g, w_b} : '0;
    assign o_item.last          = i_pos.last;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rwoc_pkg::*;

    // register slots past the last real one, writes there must be ignored
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int ITEM_TARGET = 1400;
    localparam int STALL_LIMIT = 5000;
    localparam int FULL_ALPHA  = 255;
    localparam int DIM_MAX     = 4096;

    // tracks window position and blends each source pixel onto the canvas
    class window_blend_checker;
        logic [CFG_W-1:0] regs [0:5];
        int unsigned      col_pos;
        int unsigned      row_pos;
        t_out_item        pending_writes [$];
        int               miss_count;

        function new();
            regs[REG_OFFSET_X]      = '0;
            regs[REG_OFFSET_Y]      = '0;
            regs[REG_WINDOW_WIDTH]  = 13'd1;
            regs[REG_WINDOW_HEIGHT] = 13'd1;
            regs[REG_CANVAS_WIDTH]  = 13'd1;
            regs[REG_CANVAS_HEIGHT] = 13'd1;
            col_pos    = 0;
            row_pos    = 0;
            miss_count = 0;
        endfunction

        function void flag_mismatch(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            miss_count++;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            if (idx <= REG_CANVAS_HEIGHT) begin
                regs[idx] = value[CFG_W-1:0];
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

        // zero and oversized dimensions saturate
        function int unsigned clamp_dim(logic [CFG_W-1:0] v);
            if (v == 0) return 1;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        function logic [CHAN_W-1:0] blend_channel(int unsigned s, int unsigned d,
                                                   int unsigned a);
            int unsigned acc;
            acc = s * a + d * (FULL_ALPHA - a) + 127;
            return CHAN_W'(acc / FULL_ALPHA);
        endfunction

        function void note_source_pixel(t_in_item pix);
            int          ox;
            int          oy;
            int          px;
            int          py;
            int unsigned ww;
            int unsigned wh;
            int unsigned cw;
            int unsigned ch;
            bit          hit;
            t_out_item   w;
            ox = $signed(regs[REG_OFFSET_X]);
            oy = $signed(regs[REG_OFFSET_Y]);
            ww = clamp_dim(regs[REG_WINDOW_WIDTH]);
            wh = clamp_dim(regs[REG_WINDOW_HEIGHT]);
            cw = clamp_dim(regs[REG_CANVAS_WIDTH]);
            ch = clamp_dim(regs[REG_CANVAS_HEIGHT]);
            px = ox + int'(col_pos);
            py = oy + int'(row_pos);
            hit = px >= 0 && py >= 0 && px < int'(cw) && py < int'(ch)
                  && pix.source_alpha != 0;
            w = '0;
            // clipped or transparent pixels leave every field but last at zero
            if (hit) begin
                w.write_enable = 1'b1;
                w.canvas_x     = COORD_W'(px);
                w.canvas_y     = COORD_W'(py);
                if (pix.source_alpha == FULL_ALPHA) begin
                    w.blended_pixel = {pix.source_red, pix.source_green, pix.source_blue};
                end else begin
                    w.blended_pixel = {
                        blend_channel(pix.source_red, pix.existing_pixel[23:16],
                                      pix.source_alpha),
                        blend_channel(pix.source_green, pix.existing_pixel[15:8],
                                      pix.source_alpha),
                        blend_channel(pix.source_blue, pix.existing_pixel[7:0],
                                      pix.source_alpha)};
                end
            end
            w.last = (col_pos == ww - 1) && (row_pos == wh - 1);
            pending_writes.push_back(w);
            // raster advance, counters past a shrunk window wrap here
            col_pos++;
            if (col_pos >= ww) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= wh) row_pos = 0;
            end
        endfunction

        function void check_canvas_write(t_out_item got);
            t_out_item want;
            if (pending_writes.size() == 0) begin
                flag_mismatch("canvas write with no source pixel pending");
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_enable !== want.write_enable)
                flag_mismatch($sformatf("write_enable %b, want %b",
                                        got.write_enable, want.write_enable));
            if (got.canvas_x !== want.canvas_x)
                flag_mismatch($sformatf("canvas_x %0d, want %0d",
                                        got.canvas_x, want.canvas_x));
            if (got.canvas_y !== want.canvas_y)
                flag_mismatch($sformatf("canvas_y %0d, want %0d",
                                        got.canvas_y, want.canvas_y));
            if (got.blended_pixel !== want.blended_pixel)
                flag_mismatch($sformatf("blended_pixel %06h, want %06h",
                                        got.blended_pixel, want.blended_pixel));
            if (got.last !== want.last)
                flag_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    window_blend_checker   tracker;
    bit                    steady = 1'b0;
    int                    sent_count = 0;
    int                    quiet_cycles = 0;

    rgba_window_over_compositor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly back to back, some short gaps, rare long ones
    function automatic int pick_gap();
        int roll;
        if (steady) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                            logic [7:0] a, logic [23:0] dst);
        t_in_item pix;
        pix.source_red     = r;
        pix.source_green   = g;
        pix.source_blue    = b;
        pix.source_alpha   = a;
        pix.existing_pixel = dst;
        return pix;
    endfunction

    // transparent and opaque show up often, the rest spread over the byte
    function automatic t_in_item rand_pixel();
        int         roll;
        logic [7:0] a;
        roll = $urandom_range(0, 99);
        if (roll < 15) a = 8'd0;
        else if (roll < 30) a = 8'd255;
        else if (roll < 40) a = $urandom_range(0, 1) ? 8'd1 : 8'd254;
        else a = 8'($urandom_range(0, 255));
        return make_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), a,
                          24'($urandom_range(0, 24'hFF_FFFF)));
    endfunction

    // small offsets around the canvas, sometimes anything at all
    function automatic logic [31:0] rand_offset();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(0, 16) - 8;
        if (roll < 92) return $urandom;
        return $urandom_range(0, 1) ? 32'hFFFF_F000 : 32'h0000_0FFF;
    endfunction

    function automatic logic [31:0] rand_dim(int typical);
        int          roll;
        logic [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 80) v = $urandom_range(1, typical);
        else if (roll < 88) v = $urandom_range(typical + 1, 64);
        else if (roll < 92) v = 0;
        else if (roll < 96) v = DIM_MAX;
        else v = $urandom_range(DIM_MAX + 1, 8191);
        // junk above the register width must be dropped
        if ($urandom_range(0, 9) == 0) v[31:CFG_W] = (32-CFG_W)'($urandom);
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_geometry(input logic [31:0] ox, input logic [31:0] oy,
                                    input logic [31:0] ww, input logic [31:0] wh,
                                    input logic [31:0] cw, input logic [31:0] ch);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_WINDOW_WIDTH, ww);
        write_reg(REG_WINDOW_HEIGHT, wh);
        write_reg(REG_CANVAS_WIDTH, cw);
        write_reg(REG_CANVAS_HEIGHT, ch);
    endtask

    // valid stays up across back to back items
    task automatic send_pixel(input t_in_item pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_source_pixel(pix);
        sent_count++;
    endtask

    // hold input off until every pending write is back, then let the pipe empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int burst;
        tracker  = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: one pixel window at the canvas origin
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'd255, 24'h00_0000));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'd0, 24'hFF_FFFF));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h80, 8'd128, 24'hFF_FFFF));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'd1, 24'h12_3456));
        send_pixel(make_pixel(8'hC8, 8'h64, 8'h32, 8'd254, 24'h0F_0F0F));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'd128, 24'h00_0000));
        settle();

        // window at the far canvas corner, only its first pixel lands
        program_geometry(32'd4095, 32'd4095, 32'd2, 32'd2, 32'd4096, 32'd4096);
        send_pixel(make_pixel(8'hA5, 8'h5A, 8'hFF, 8'd255, 24'h00_0000));
        send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'd200, 24'hAB_CDEF));
        send_pixel(make_pixel(8'h44, 8'h55, 8'h66, 8'd77, 24'h01_0203));
        send_pixel(make_pixel(8'h77, 8'h88, 8'h99, 8'd255, 24'hFF_FFFF));
        settle();

        // most negative offsets, zero and oversized dimensions, spare slots
        program_geometry(32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'd0,
                         32'd0, 32'd8191);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0005);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'd255, 24'hFF_FFFF));
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'd100, 24'h40_5060));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'd0, 24'h00_0000));
        settle();

        // shrink the window while the column counter sits past its new width
        program_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd3, 32'd2, 32'd2);
        repeat (9) send_pixel(rand_pixel());
        settle();

        // random geometry phases, items per phase rarely match the window
        while (sent_count < ITEM_TARGET) begin
            steady = ($urandom_range(0, 4) == 0);
            program_geometry(rand_offset(), rand_offset(), rand_dim(8), rand_dim(8),
                             rand_dim(12), rand_dim(12));
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            burst = $urandom_range(10, 90);
            repeat (burst) send_pixel(rand_pixel());
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0) tracker.flag_mismatch("source pixels never written back");
        if (tracker.miss_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random back pressure and the check of each write
    initial begin
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.check_canvas_write(o_out_item);
            if (stall == 0 && $urandom_range(0, 3) == 0) stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> sim.f
rtl/core/rwoc_pkg.sv
rtl/core/rwoc_cfg.sv
rtl/core/rwoc_position.sv
rtl/core/rwoc_blend.sv
rtl/core/rgba_window_over_compositor.sv
verif/tb_top.sv
